### design/ctne_pkg.sv
// Types, character constants and per-byte encoding functions of the line-tag encoder.
package ctne_pkg;

  localparam int unsigned MaxOut = 16;

  typedef logic [7:0] byte_t;

  localparam byte_t ChNul   = 8'h00;
  localparam byte_t ChLf    = 8'h0A;
  localparam byte_t ChHash  = 8'h23;
  localparam byte_t ChDot   = 8'h2E;
  localparam byte_t ChZero  = 8'h30;
  localparam byte_t ChTwo   = 8'h32;
  localparam byte_t ChThree = 8'h33;
  localparam byte_t ChUpA   = 8'h41;
  localparam byte_t ChLowA  = 8'h61;

  // Output bytes gathered for one transaction, element 0 goes out first.
  typedef struct packed {
    byte_t [MaxOut-1:0] b;
    logic  [4:0]        n;
  } olist_t;

  function automatic logic is_digit(byte_t b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_upper(byte_t b);
    return (b >= 8'h41) && (b <= 8'h5A);
  endfunction

  function automatic logic is_lower(byte_t b);
    return (b >= 8'h61) && (b <= 8'h7A);
  endfunction

  function automatic logic is_ws(byte_t b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0B) || (b == 8'h0C) || (b == 8'h0D);
  endfunction

  function automatic olist_t put(olist_t l, byte_t c);
    olist_t r;
    r = l;
    if (l.n < 5'(MaxOut)) begin
      r.b[l.n[3:0]] = c;
      r.n = l.n + 5'd1;
    end
    return r;
  endfunction

  // Decimal digits {hundreds, tens, ones} of a value below 400.
  function automatic logic [11:0] dec3(logic [8:0] v);
    logic [1:0] h;
    logic [8:0] r;
    logic [6:0] r2;
    logic [3:0] t;
    logic [6:0] o;
    priority if (v >= 9'd300) h = 2'd3;
    else if (v >= 9'd200) h = 2'd2;
    else if (v >= 9'd100) h = 2'd1;
    else h = 2'd0;
    unique case (h)
      2'd3:    r = v - 9'd300;
      2'd2:    r = v - 9'd200;
      2'd1:    r = v - 9'd100;
      default: r = v;
    endcase
    r2 = r[6:0];
    t  = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (r2 >= 7'(10 * k)) t = 4'(k);
    end
    o = r2 - 7'({3'd0, t} * 7'd10);
    return {2'b00, h, t, o[3:0]};
  endfunction

  function automatic byte_t digit_char(logic [3:0] d);
    return ChZero + {4'd0, d};
  endfunction

  function automatic olist_t put3(olist_t l, logic [8:0] v);
    logic [11:0] d;
    olist_t r;
    d = dec3(v);
    r = put(l, digit_char(d[11:8]));
    r = put(r, digit_char(d[7:4]));
    r = put(r, digit_char(d[3:0]));
    return r;
  endfunction

  // Leading zeros suppressed.
  function automatic olist_t put_num(olist_t l, logic [8:0] v);
    logic [11:0] d;
    olist_t r;
    d = dec3(v);
    r = l;
    if (v >= 9'd100) r = put(r, digit_char(d[11:8]));
    if (v >= 9'd10) r = put(r, digit_char(d[7:4]));
    r = put(r, digit_char(d[3:0]));
    return r;
  endfunction

  function automatic olist_t put_code(olist_t l, byte_t b);
    olist_t r;
    priority if (is_digit(b)) begin
      r = put(l, ChZero);
      r = put(r, b);
    end else if (is_upper(b)) begin
      r = put3(l, 9'd100 + {1'b0, b[6:0] - ChUpA[6:0], 1'b0});
    end else if (is_lower(b)) begin
      r = put3(l, 9'd101 + {1'b0, b[6:0] - ChLowA[6:0], 1'b0});
    end else if (b[7]) begin
      // negative as a signed byte
      r = put3(l, {1'b0, b} - 9'd56);
    end else begin
      r = put3(l, 9'd200 + {2'b00, b[6:0]});
    end
    return r;
  endfunction

  function automatic olist_t put_tag(olist_t l, byte_t c);
    olist_t r;
    r = put(l, c);
    r = put(r, ChZero);
    r = put(r, ChZero);
    r = put(r, ChDot);
    return r;
  endfunction

  function automatic logic [8:0] letter_num(byte_t b);
    byte_t u;
    logic [8:0] num;
    u = is_lower(b) ? b - 8'h20 : b;
    unique case (u)
      8'h58:   num = 9'd101;
      8'h59:   num = 9'd102;
      8'h57:   num = 9'd103;
      8'h5A:   num = 9'd104;
      8'h4D:   num = 9'd105;
      default: num = 9'd106 + {4'd0, u[4:0] - ChUpA[4:0]};
    endcase
    return num;
  endfunction

endpackage

### design/chromosome_tag_numeric_encoder.sv
// Top level of the line-tag numeric encoder: input register, encode logic, output shifter.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------------
//   in      | into      | in_valid_i / in_stall_o   | in_byte_i, end_of_stream_i
//   out     | out of    | out_valid_o / out_stall_i | out_byte_o, last_of_run_o
//
// An input transaction lands in the input register; the encode logic turns it into up to
// 16 bytes in one pass and loads them into the output shifter, which sends one byte per
// cycle while out_stall_i is low. The shifter is reloaded in the cycle its last byte is
// taken, so no bubble appears between runs. rst_ni clears the line state and both valid
// flags. A stalled output holds its byte; the input stalls only while the shifter is busy.
module chromosome_tag_numeric_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_stream_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);
  import ctne_pkg::*;

  // line phases
  typedef enum logic [3:0] {
    PH_START  = 4'd0,
    PH_PREFIX = 4'd1,
    PH_AFTER  = 4'd2,
    PH_DIGIT  = 4'd3,
    PH_POST   = 4'd4,
    PH_FRAC   = 4'd5,
    PH_COPY   = 4'd6,
    PH_DROP   = 4'd7
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    byte_t [1:0] held;
    logic  [1:0] cnt;
    logic  [3:0] fd;
  } lstate_t;

  typedef struct packed {
    lstate_t s;
    olist_t  l;
  } step_t;

  // A byte inside the coded part of the token.
  function automatic step_t frac_byte(step_t x, byte_t b);
    step_t r;
    r = x;
    priority if (b == ChLf) begin
      r.l = put(r.l, ChLf);
      r.s.phase = PH_START;
    end else if (b == ChNul) begin
      r.s.phase = PH_DROP;
    end else if (is_ws(b)) begin
      r.l = put(r.l, b);
      r.s.phase = PH_COPY;
    end else begin
      r.l = put_code(r.l, b);
      r.s.phase = PH_FRAC;
    end
    return r;
  endfunction

  // A byte straight after the chromosome number; more token gets a dot first.
  function automatic step_t post_byte(step_t x, byte_t b);
    step_t r;
    r = x;
    if (b != ChLf && b != ChNul && !is_ws(b)) r.l = put(r.l, ChDot);
    return frac_byte(r, b);
  endfunction

  // One byte through the line state machine, appending to the output list.
  function automatic step_t ctne_step(step_t x, byte_t b);
    step_t r;
    byte_t u;
    r = x;
    u = is_upper(b) ? b + 8'h20 : b;
    unique case (x.s.phase)
      PH_START: begin
        priority if (is_ws(b)) begin
          r = x;
        end else if (b == ChHash) begin
          r.l = put(r.l, ChZero);
          r.l = put(r.l, ChDot);
          r.s.phase = PH_FRAC;
        end else if (u == 8'h63) begin
          r.s.held[0] = b;
          r.s.cnt = 2'd1;
          r.s.phase = PH_PREFIX;
        end else begin
          r.l = put_tag(r.l, ChThree);
          r = frac_byte(r, b);
        end
      end
      PH_PREFIX: begin
        priority if (x.s.cnt == 2'd1 && u == 8'h68) begin
          r.s.held[1] = b;
          r.s.cnt = 2'd2;
        end else if (x.s.cnt == 2'd2 && u == 8'h72) begin
          r.s.cnt = 2'd0;
          r.s.phase = PH_AFTER;
        end else begin
          // cut inside the prefix: fall back to the untagged form
          r.l = put_tag(r.l, ChThree);
          if (x.s.cnt >= 2'd1) r.l = put_code(r.l, x.s.held[0]);
          if (x.s.cnt >= 2'd2) r.l = put_code(r.l, x.s.held[1]);
          r.s.cnt = 2'd0;
          r = frac_byte(r, b);
        end
      end
      PH_AFTER: begin
        priority if (is_digit(b)) begin
          r.s.fd = b[3:0];
          r.s.phase = PH_DIGIT;
        end else if (is_upper(b) || is_lower(b)) begin
          r.l = put_num(r.l, letter_num(b));
          r.s.phase = PH_POST;
        end else begin
          r.l = put_tag(r.l, ChTwo);
          r = frac_byte(r, b);
        end
      end
      PH_DIGIT: begin
        if (is_digit(b)) begin
          r.l = put_num(r.l, 9'({5'd0, x.s.fd} * 9'd10) + {5'd0, b[3:0]} + 9'd1);
          r.s.phase = PH_POST;
        end else begin
          r.l = put_num(r.l, {5'd0, x.s.fd} + 9'd1);
          r = post_byte(r, b);
        end
      end
      PH_POST: r = post_byte(x, b);
      PH_FRAC: r = frac_byte(x, b);
      PH_COPY: begin
        priority if (b == ChLf) begin
          r.l = put(r.l, ChLf);
          r.s.phase = PH_START;
        end else if (b == ChNul) begin
          r.s.phase = PH_DROP;
        end else begin
          r.l = put(r.l, b);
        end
      end
      default: begin
        // rest of the line after a NUL is dropped
        if (b == ChLf) begin
          r.l = put(r.l, ChLf);
          r.s.phase = PH_START;
        end
      end
    endcase
    return r;
  endfunction

  // input register
  logic  in_vld_q;
  byte_t in_byte_q;
  logic  eos_q;

  // line state
  lstate_t st_q;

  // output shifter: element 0 is the byte on the port
  byte_t [MaxOut-1:0] obuf_q;
  logic  [4:0]        cnt_q;

  step_t step_a;
  step_t step_b;
  logic  out_take;
  logic  load;

  assign out_valid_o   = (cnt_q != 5'd0);
  assign out_byte_o    = obuf_q[0];
  assign last_of_run_o = (cnt_q == 5'd1);
  assign out_take      = out_valid_o && !out_stall_i;

  // The held byte can move on once the shifter is empty or about to be.
  assign load       = in_vld_q && ((cnt_q == 5'd0) || ((cnt_q == 5'd1) && out_take));
  assign in_stall_o = in_vld_q && !load;

  // Encode pass; an end of stream without newline runs a newline through as well.
  always_comb begin
    step_a.s = st_q;
    step_a.l = '0;
    step_a   = ctne_step(step_a, in_byte_q);
    step_b   = (eos_q && (in_byte_q != ChLf)) ? ctne_step(step_a, ChLf) : step_a;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
      eos_q     <= end_of_stream_i;
    end
  end

  // Line state and output shifter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase <= PH_START;
      st_q.held  <= '0;
      st_q.cnt   <= 2'd0;
      st_q.fd    <= 4'd0;
      cnt_q      <= 5'd0;
      obuf_q     <= '0;
    end else if (load) begin
      st_q   <= step_b.s;
      cnt_q  <= step_b.l.n;
      obuf_q <= step_b.l.b;
    end else if (out_take) begin
      cnt_q  <= cnt_q - 5'd1;
      obuf_q <= {ChNul, obuf_q[MaxOut-1:1]};
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 5'(MaxOut))
    else $error("output count beyond shifter depth");

  a_load_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> ((cnt_q == 5'd0) || ((cnt_q == 5'd1) && out_take)))
    else $error("shifter reloaded while bytes remain");

  a_stall_has_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q)
    else $error("input stalled with an empty input register");

  a_eos_line_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && eos_q) |=> (st_q.phase == PH_START))
    else $error("line not finished at end of stream");
`endif

endmodule

### test/chromosome_tag_numeric_encoder_tb.sv
// Self-checking testbench for chromosome_tag_numeric_encoder: random text lines, predicted bytes.
`timescale 1ns / 100ps

module chromosome_tag_numeric_encoder_tb;
  import ctne_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned LongHold = 120;
  localparam int unsigned MaxShown = 40;

  localparam byte_t CaseBit = 8'h20;
  localparam byte_t LoC = "c";
  localparam byte_t LoH = "h";
  localparam byte_t LoR = "r";

  // predictor line phases
  typedef enum logic [3:0] {
    PH_START,
    PH_PREFIX,
    PH_AFTER,
    PH_DIGIT,
    PH_POST,
    PH_FRAC,
    PH_COPY,
    PH_DROP
  } phase_e;

  // one input transaction: stream byte plus end-of-stream flag
  typedef struct {
    byte_t b;
    logic  eos;
  } text_item_t;

  // one output transaction as the encoder should send it
  typedef struct {
    byte_t ch;
    logic  last;
  } coded_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_eos = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  text_item_t  text_q[$];     // stream bytes not yet offered
  coded_byte_t owed_bytes[$]; // encoded bytes predicted but not yet seen
  byte_t       run_q[$];      // bytes of the transaction being predicted

  // predictor copy of the line state
  phase_e      ln_phase = PH_START;
  byte_t       held_b[2];
  int unsigned held_n = 0;
  logic [3:0]  fdig = 4'd0;

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned queued = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          in_took = 1'b0;
  bit          calm = 1'b0;   // no idling on either side in the closing stretch
  bit          quiet = 1'b0;  // short idle-free stretches
  bit          hold_req = 1'b0;

  chromosome_tag_numeric_encoder dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .in_byte_i      (in_byte),
    .end_of_stream_i(in_eos),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_byte_o     (out_byte),
    .last_of_run_o  (out_last)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Character classes
  // ---------------------------------------------------------------------------
  function automatic bit digit_ch(byte_t c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit upper_ch(byte_t c);
    return c >= "A" && c <= "Z";
  endfunction

  function automatic bit lower_ch(byte_t c);
    return c >= "a" && c <= "z";
  endfunction

  // HT, VT, FF, CR and space; LF is a line end, not a blank
  function automatic bit blank_ch(byte_t c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D;
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // The encoder caps a transaction at MaxOut bytes; anything beyond is lost.
  function automatic void emit(byte_t c);
    if (run_q.size() < MaxOut) run_q.push_back(c);
  endfunction

  // Decimal print; full forces three digits, otherwise leading zeros go.
  function automatic void emit_dec(int v, bit full);
    if (full || v >= 100) emit(ChZero + byte_t'((v / 100) % 10));
    if (full || v >= 10) emit(ChZero + byte_t'((v / 10) % 10));
    emit(ChZero + byte_t'(v % 10));
  endfunction

  function automatic void emit_tag(byte_t lead);
    emit(lead);
    emit(ChZero);
    emit(ChZero);
    emit(ChDot);
  endfunction

  // Token byte code: digit d -> "0d", letters 100+2i / 101+2i, rest 200+signed byte.
  function automatic void emit_code(byte_t c);
    if (digit_ch(c)) begin
      emit(ChZero);
      emit(c);
    end else if (upper_ch(c)) begin
      emit_dec(100 + 2 * (int'(c) - int'(ChUpA)), 1'b1);
    end else if (lower_ch(c)) begin
      emit_dec(101 + 2 * (int'(c) - int'(ChLowA)), 1'b1);
    end else begin
      emit_dec(200 + int'($signed(c)), 1'b1);
    end
  endfunction

  // A byte inside the coded part of the token.
  function automatic void token_byte(byte_t c);
    if (c == ChLf) begin
      emit(ChLf);
      ln_phase = PH_START;
    end else if (c == ChNul) begin
      ln_phase = PH_DROP;
    end else if (blank_ch(c)) begin
      emit(c);
      ln_phase = PH_COPY;
    end else begin
      emit_code(c);
      ln_phase = PH_FRAC;
    end
  endfunction

  // A byte straight after the chromosome number: a dot goes in front of more token.
  function automatic void after_tag(byte_t c);
    if (c != ChLf && c != ChNul && !blank_ch(c)) emit(ChDot);
    token_byte(c);
  endfunction

  function automatic void encode_byte(byte_t c);
    byte_t lc;
    byte_t uc;
    int    num;
    int    i;
    lc = upper_ch(c) ? (c | CaseBit) : c;
    case (ln_phase)
      PH_START: begin
        if (blank_ch(c)) begin
          // leading blank, dropped
        end else if (c == ChHash) begin
          emit(ChZero);
          emit(ChDot);
          ln_phase = PH_FRAC;
        end else if (lc == LoC) begin
          held_b[0] = c;
          held_n = 1;
          ln_phase = PH_PREFIX;
        end else begin
          emit_tag(ChThree);
          token_byte(c);
        end
      end
      PH_PREFIX: begin
        if (held_n == 1 && lc == LoH) begin
          held_b[1] = c;
          held_n = 2;
        end else if (held_n == 2 && lc == LoR) begin
          held_n = 0;
          ln_phase = PH_AFTER;
        end else begin
          // prefix broken off: untagged form, held bytes coded first
          emit_tag(ChThree);
          for (i = 0; i < int'(held_n); i++) emit_code(held_b[i]);
          held_n = 0;
          token_byte(c);
        end
      end
      PH_AFTER: begin
        if (digit_ch(c)) begin
          fdig = c[3:0];
          ln_phase = PH_DIGIT;
        end else if (upper_ch(c) || lower_ch(c)) begin
          uc = c & ~CaseBit;
          case (uc)
            "X":     num = 101;
            "Y":     num = 102;
            "W":     num = 103;
            "Z":     num = 104;
            "M":     num = 105;
            default: num = 106 + int'(uc) - int'(ChUpA);
          endcase
          emit_dec(num, 1'b0);
          ln_phase = PH_POST;
        end else begin
          emit_tag(ChTwo);
          token_byte(c);
        end
      end
      PH_DIGIT: begin
        if (digit_ch(c)) begin
          emit_dec(10 * int'(fdig) + int'(c[3:0]) + 1, 1'b0);
          ln_phase = PH_POST;
        end else begin
          emit_dec(int'(fdig) + 1, 1'b0);
          after_tag(c);
        end
      end
      PH_POST: after_tag(c);
      PH_FRAC: token_byte(c);
      PH_COPY: begin
        if (c == ChLf) begin
          emit(ChLf);
          ln_phase = PH_START;
        end else if (c == ChNul) begin
          ln_phase = PH_DROP;
        end else begin
          emit(c);
        end
      end
      default: begin
        // rest of line after a NUL is swallowed
        if (c == ChLf) begin
          emit(ChLf);
          ln_phase = PH_START;
        end
      end
    endcase
  endfunction

  // Works out every byte one input transaction causes; end of stream adds a newline.
  function automatic void predict_run(byte_t c, logic eos);
    coded_byte_t cb;
    run_q.delete();
    encode_byte(c);
    if (eos && c != ChLf) encode_byte(ChLf);
    foreach (run_q[i]) begin
      cb.ch = run_q[i];
      cb.last = (i == run_q.size() - 1);
      owed_bytes.push_back(cb);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void add_item(byte_t c, logic eos);
    text_item_t it;
    it.b = c;
    it.eos = eos;
    text_q.push_back(it);
    queued++;
  endfunction

  function automatic void add_text(string s);
    foreach (s[i]) add_item(byte_t'(s[i]), 1'b0);
  endfunction

  function automatic byte_t pick_blank();
    case ($urandom_range(0, 4))
      0:       return 8'h09;
      1:       return 8'h0B;
      2:       return 8'h0C;
      3:       return 8'h0D;
      default: return 8'h20;
    endcase
  endfunction

  function automatic byte_t mixed_case(byte_t lc);
    return $urandom_range(0, 1) ? (lc ^ CaseBit) : lc;
  endfunction

  // Any byte that stays inside a token.
  function automatic byte_t pick_token_char();
    byte_t c;
    case ($urandom_range(0, 3))
      0: c = byte_t'($urandom_range(8'h30, 8'h39));
      1: c = byte_t'($urandom_range(8'h41, 8'h5A));
      2: c = byte_t'($urandom_range(8'h61, 8'h7A));
      default: begin
        c = byte_t'($urandom_range(1, 255));
        while (blank_ch(c) || c == ChLf) c = byte_t'($urandom_range(1, 255));
      end
    endcase
    return c;
  endfunction

  // One random line; mostly well-formed tags with random content, some noise.
  function automatic void queue_line();
    byte_t ln[$];
    byte_t c;
    int    kind;
    int    sel;
    kind = $urandom_range(0, 19);
    repeat ($urandom_range(0, 2) * ($urandom_range(0, 2) == 0)) ln.push_back(pick_blank());
    if (kind < 10) begin
      ln.push_back(mixed_case(LoC));
      ln.push_back(mixed_case(LoH));
      ln.push_back(mixed_case(LoR));
      case ($urandom_range(0, 3))
        0: ln.push_back(byte_t'($urandom_range(8'h30, 8'h39)));
        1: begin
          ln.push_back(byte_t'($urandom_range(8'h30, 8'h39)));
          ln.push_back(byte_t'($urandom_range(8'h30, 8'h39)));
        end
        2: ln.push_back(mixed_case(byte_t'($urandom_range(8'h61, 8'h7A))));
        default: begin
          c = byte_t'($urandom_range(0, 255));
          while (digit_ch(c) || upper_ch(c) || lower_ch(c)) c = byte_t'($urandom_range(0, 255));
          ln.push_back(c);
        end
      endcase
      repeat ($urandom_range(0, 3)) ln.push_back(pick_token_char());
    end else if (kind < 12) begin
      ln.push_back(ChHash);
      repeat ($urandom_range(0, 3)) ln.push_back(pick_token_char());
    end else if (kind < 14) begin
      repeat ($urandom_range(1, 3)) ln.push_back(pick_token_char());
    end else if (kind < 16) begin
      // prefix cut short
      ln.push_back(mixed_case(LoC));
      if ($urandom_range(0, 1)) ln.push_back(mixed_case(LoH));
      ln.push_back(byte_t'($urandom_range(0, 255)));
    end else begin
      // raw noise, end of stream anywhere
      repeat ($urandom_range(0, 8)) add_item(byte_t'($urandom_range(0, 255)),
                                             $urandom_range(0, 15) == 0);
    end
    if ($urandom_range(0, 2) != 0) begin
      ln.push_back(pick_blank());
      repeat ($urandom_range(0, 6)) begin
        c = byte_t'($urandom_range(1, 255));
        if (c == ChLf || $urandom_range(0, 11) == 0) c = ChNul;
        ln.push_back(c);
      end
    end
    // sel 0: stream ends on the last byte, no newline; sel 1: ends on the newline
    sel = $urandom_range(0, 11);
    foreach (ln[i]) add_item(ln[i], sel == 0 && i == ln.size() - 1);
    if (sel != 0 || ln.size() == 0) add_item(ChLf, sel == 1);
  endfunction

  function automatic void queue_random(int unsigned n);
    int unsigned stop_at;
    stop_at = queued + n;
    while (queued < stop_at) queue_line();
  endfunction

  // Sender paused until the encoder has delivered everything owed.
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (text_q.size() != 0 || in_valid || owed_bytes.size() != 0);
  endtask

  task automatic flag_error(string msg);
    errors++;
    if (errors <= MaxShown) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: new transaction at the falling edge once the last one was taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    text_item_t it;
    if (rst_n && (!in_valid || in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (!calm && !quiet && text_q.size() != 0 && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(0, 4);
        in_valid <= 1'b0;
      end else if (text_q.size() != 0) begin
        it = text_q.pop_front();
        in_valid <= 1'b1;
        in_byte <= it.b;
        in_eos <= it.eos;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall bursts, plus one long hold-off that backs the encoder up
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LongHold - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each accepted input, check each accepted output
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    coded_byte_t want;
    if (rst_n) begin
      in_took = in_valid && !in_stall;
      if (in_took) predict_run(in_byte, in_eos);
      if (out_valid && !out_stall) begin
        if (owed_bytes.size() == 0) begin
          flag_error($sformatf("byte %02h with nothing owed", out_byte));
        end else begin
          want = owed_bytes.pop_front();
          if (out_byte !== want.ch)
            flag_error($sformatf("out_byte %02h, want %02h", out_byte, want.ch));
          if (out_last !== want.last)
            flag_error($sformatf("last_of_run %b, want %b (byte %02h)", out_last, want.last,
                                 want.ch));
        end
      end
    end
  end

  // Cycle count, watchdog and the occasional idle-free stretch.
  always @(posedge clk) begin
    cycles++;
    if (cycles % 48 == 0) quiet = ($urandom_range(0, 3) == 0);
    if (cycles >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: blanks dropped, two-digit tag at 99, '#' line with a high byte and a NUL,
    // prefix cut after "Ch", empty line, end of stream without newline, "chr" plus
    // non-alphanumeric, end of stream on a newline.
    add_text(" \tchr99a\n");
    add_item(ChHash, 1'b0);
    add_item(8'hFF, 1'b0);
    add_item(ChNul, 1'b0);
    add_item("z", 1'b0);
    add_item(ChLf, 1'b0);
    add_text("Ch\n");
    add_text("\n");
    add_text("cHR");
    add_item("m", 1'b1);
    add_text("chr_");
    add_item(8'h80, 1'b0);
    add_item(ChLf, 1'b1);
    wait_drained();

    // long receiver hold-off at the start: input must back up and stall
    hold_req = 1'b1;
    queue_random(180);
    wait_drained();

    queue_random(180);
    wait_drained();

    // closing stretch at full rate
    calm = 1'b1;
    queue_random(80);
    wait_drained();

    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && owed_bytes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### chromosome_tag_numeric_encoder.f
design/ctne_pkg.sv
design/chromosome_tag_numeric_encoder.sv
test/chromosome_tag_numeric_encoder_tb.sv
